// ===== hw/rtl/kso_pkg.sv =====
`timescale 1ns / 1ps

package kso_pkg;

  // Q16.16 sample
  localparam int unsigned VAL_W  = 32;
  // Q4.12 coefficient
  localparam int unsigned COEF_W = 16;
  // innovation y - yhat, exact
  localparam int unsigned INNOV_W = 33;
  localparam int unsigned PROD_W  = COEF_W + INNOV_W;
  // five products of up to 2^47 each, plus rounding headroom
  localparam int unsigned ACC_W   = 52;
  localparam int unsigned FRAC_SH = 12;

  // config bus
  localparam int unsigned PADDR_W = 6;
  localparam int unsigned PDATA_W = 64;

  // register indexes (byte address 8*i)
  localparam logic [2:0] REG_A = 3'd0;
  localparam logic [2:0] REG_B = 3'd1;
  localparam logic [2:0] REG_C = 3'd2;
  localparam logic [2:0] REG_D = 3'd3;
  localparam logic [2:0] REG_L = 3'd4;

  typedef struct packed {
    logic signed [VAL_W-1:0] drive_u;
    logic signed [VAL_W-1:0] meas_angle;
    logic signed [VAL_W-1:0] meas_rate;
  } kso_in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] est_angle;
    logic signed [VAL_W-1:0] est_rate;
    logic signed [VAL_W-1:0] pred_angle;
    logic signed [VAL_W-1:0] pred_rate;
  } kso_out_t;

endpackage

// ===== hw/rtl/kalman_state_observer_step.sv =====
`timescale 1ns / 1ps

// Two-state steady-state Kalman observer. Each request (drive_u, meas_angle,
// meas_rate) first predicts yhat = C*xhat + D*u from the stored estimate, then
// updates xhat = A*xhat + B*u + L*(y - yhat); the result carries the new
// estimate and the prediction, all Q16.16 and saturated to 32 bits. One
// 16x33-bit signed multiplier feeding a 52-bit accumulator does all sixteen
// products in turn, one per cycle. The next request is taken in the cycle
// after the result moves to the output register, so requests do not overlap
// and a stall on the output side holds off the next one. The output register
// holds the finished result while the next request is being worked.
// Coefficients are signed Q4.12, written over the APB port at byte address
// 8*i (A, B, C, D, L); write them only while idle.
// Rounding is half up (add 2^11, floor-shift by 12). The estimate resets to 0.
module kalman_state_observer_step (
  input  logic                        clk,
  input  logic                        rst,
  // sample channel
  input  logic                        sample_valid,
  output logic                        sample_stall,
  input  kso_pkg::kso_in_t            sample,
  // result channel
  output logic                        result_valid,
  input  logic                        result_stall,
  output kso_pkg::kso_out_t           result,
  // APB config
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [kso_pkg::PADDR_W-1:0] paddr,
  input  logic [kso_pkg::PDATA_W-1:0] pwdata,
  output logic [kso_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);

  // accumulation groups, in issue order
  localparam logic [1:0] GRP_PRED0 = 2'd0;
  localparam logic [1:0] GRP_PRED1 = 2'd1;
  localparam logic [1:0] GRP_NEXT0 = 2'd2;
  localparam logic [1:0] GRP_NEXT1 = 2'd3;

  localparam int unsigned VW = kso_pkg::VAL_W;
  localparam int unsigned CW = kso_pkg::COEF_W;
  localparam int unsigned IW = kso_pkg::INNOV_W;
  localparam int unsigned PW = kso_pkg::PROD_W;
  localparam int unsigned AW = kso_pkg::ACC_W;
  localparam int unsigned QW = AW - kso_pkg::FRAC_SH;

  // ---------------- config registers ----------------
  logic [63:0] a_matrix;
  logic [31:0] b_vector;
  logic [63:0] c_matrix;
  logic [31:0] d_vector;
  logic [63:0] l_matrix;

  logic [2:0] reg_idx;
  logic       cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_matrix <= '0;
      b_vector <= '0;
      c_matrix <= '0;
      d_vector <= '0;
      l_matrix <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        kso_pkg::REG_A: a_matrix <= pwdata;
        kso_pkg::REG_B: b_vector <= pwdata[31:0];
        kso_pkg::REG_C: c_matrix <= pwdata;
        kso_pkg::REG_D: d_vector <= pwdata[31:0];
        kso_pkg::REG_L: l_matrix <= pwdata;
        default: ;  // unmapped: ignored
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      kso_pkg::REG_A: prdata = a_matrix;
      kso_pkg::REG_B: prdata = {32'd0, b_vector};
      kso_pkg::REG_C: prdata = c_matrix;
      kso_pkg::REG_D: prdata = {32'd0, d_vector};
      kso_pkg::REG_L: prdata = l_matrix;
      default:        prdata = '0;
    endcase
  end

  // ---------------- control ----------------
  logic       busy;      // request taken, result not yet in output register
  logic       issuing;   // multiplier steps still to issue
  logic [3:0] step;
  logic       pend;      // result finished, waiting for output register
  logic       accept;

  assign sample_stall = busy;
  assign accept       = sample_valid & ~busy;

  // latched request and state
  logic signed [VW-1:0] drive_u;
  logic signed [VW-1:0] meas0;
  logic signed [VW-1:0] meas1;
  logic signed [VW-1:0] est0;
  logic signed [VW-1:0] est1;
  logic signed [IW-1:0] innov0;
  logic signed [IW-1:0] innov1;
  logic signed [VW-1:0] pred0;
  logic signed [VW-1:0] pred1;
  logic signed [VW-1:0] next0;
  logic signed [VW-1:0] next1;

  // ---------------- operand select ----------------
  logic signed [CW-1:0] coef_sel;
  logic signed [IW-1:0] val_sel;
  logic [1:0]           grp_sel;
  logic                 first_sel;
  logic                 last_sel;

  logic signed [IW-1:0] e0_x, e1_x, u_x;
  assign e0_x = IW'(est0);
  assign e1_x = IW'(est1);
  assign u_x  = IW'(drive_u);

  always_comb begin
    first_sel = 1'b0;
    last_sel  = 1'b0;
    unique case (step)
      4'd0:  begin coef_sel = c_matrix[15:0];  val_sel = e0_x;   first_sel = 1'b1; end
      4'd1:  begin coef_sel = c_matrix[31:16]; val_sel = e1_x;   end
      4'd2:  begin coef_sel = d_vector[15:0];  val_sel = u_x;    last_sel = 1'b1; end
      4'd3:  begin coef_sel = c_matrix[47:32]; val_sel = e0_x;   first_sel = 1'b1; end
      4'd4:  begin coef_sel = c_matrix[63:48]; val_sel = e1_x;   end
      4'd5:  begin coef_sel = d_vector[31:16]; val_sel = u_x;    last_sel = 1'b1; end
      4'd6:  begin coef_sel = a_matrix[15:0];  val_sel = e0_x;   first_sel = 1'b1; end
      4'd7:  begin coef_sel = a_matrix[31:16]; val_sel = e1_x;   end
      4'd8:  begin coef_sel = b_vector[15:0];  val_sel = u_x;    end
      4'd9:  begin coef_sel = l_matrix[15:0];  val_sel = innov0; end
      4'd10: begin coef_sel = l_matrix[31:16]; val_sel = innov1; last_sel = 1'b1; end
      4'd11: begin coef_sel = a_matrix[47:32]; val_sel = e0_x;   first_sel = 1'b1; end
      4'd12: begin coef_sel = a_matrix[63:48]; val_sel = e1_x;   end
      4'd13: begin coef_sel = b_vector[31:16]; val_sel = u_x;    end
      4'd14: begin coef_sel = l_matrix[47:32]; val_sel = innov0; end
      4'd15: begin coef_sel = l_matrix[63:48]; val_sel = innov1; last_sel = 1'b1; end
      default: begin coef_sel = '0; val_sel = '0; end
    endcase
    // innovation 1 is ready from step 8 on; step 10 is the first use
    if (step < 4'd3)       grp_sel = GRP_PRED0;
    else if (step < 4'd6)  grp_sel = GRP_PRED1;
    else if (step < 4'd11) grp_sel = GRP_NEXT0;
    else                   grp_sel = GRP_NEXT1;
  end

  // ---------------- MAC pipeline ----------------
  logic signed [PW-1:0] prod;
  logic                 p_vld, p_first, p_last;
  logic [1:0]           p_grp;
  logic signed [AW-1:0] acc;
  logic                 a_done;
  logic [1:0]           a_grp;

  always_ff @(posedge clk) begin
    prod    <= coef_sel * val_sel;
    p_first <= first_sel;
    p_last  <= last_sel;
    p_grp   <= grp_sel;
    if (p_vld) begin
      acc <= p_first ? AW'(prod) : acc + AW'(prod);
    end
    a_grp <= p_grp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld  <= 1'b0;
      a_done <= 1'b0;
    end else begin
      p_vld  <= issuing;
      a_done <= p_vld & p_last;
    end
  end

  // rescale: add half, floor-shift, saturate
  logic signed [AW-1:0] rnd;
  logic signed [QW-1:0] quo;
  logic signed [VW-1:0] sat;

  assign rnd = acc + AW'(2048);
  assign quo = QW'(rnd >>> kso_pkg::FRAC_SH);

  always_comb begin
    if (quo > QW'(64'sd2147483647))       sat = 32'sh7fffffff;
    else if (quo < -QW'(64'sd2147483648)) sat = 32'sh80000000;
    else                                  sat = VW'(quo);
  end

  // ---------------- sequencer and result ----------------
  always_ff @(posedge clk) begin
    if (accept) begin
      drive_u <= sample.drive_u;
      meas0   <= sample.meas_angle;
      meas1   <= sample.meas_rate;
    end
    if (a_done) begin
      unique case (a_grp)
        GRP_PRED0: begin
          pred0  <= sat;
          innov0 <= IW'(meas0) - IW'(sat);
        end
        GRP_PRED1: begin
          pred1  <= sat;
          innov1 <= IW'(meas1) - IW'(sat);
        end
        GRP_NEXT0: next0 <= sat;
        GRP_NEXT1: next1 <= sat;
        default: ;
      endcase
    end
    if (pend && (!result_valid || !result_stall)) begin
      result.est_angle  <= next0;
      result.est_rate   <= next1;
      result.pred_angle <= pred0;
      result.pred_rate  <= pred1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      issuing      <= 1'b0;
      step         <= '0;
      pend         <= 1'b0;
      result_valid <= 1'b0;
      est0         <= '0;
      est1         <= '0;
    end else begin
      if (accept) begin
        busy    <= 1'b1;
        issuing <= 1'b1;
        step    <= '0;
      end else if (issuing) begin
        step <= step + 4'd1;
        if (step == 4'd15) issuing <= 1'b0;
      end

      // last group closes: commit state, hand off to output register
      if (a_done && a_grp == GRP_NEXT1) begin
        pend <= 1'b1;
        est0 <= next0;
        est1 <= sat;
      end

      if (pend && (!result_valid || !result_stall)) begin
        pend         <= 1'b0;
        busy         <= 1'b0;
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== test/kalman_state_observer_step_test.sv =====
`timescale 1ns / 1ps

// Checks the two-state observer step against an in-bench model of the same
// fixed-point math.
// Each accepted request advances the model estimate and queues the expected
// result. Each accepted result is compared with the oldest queued one.
module kalman_state_observer_step_test;
  import kso_pkg::*;

  localparam int CYCLE_LIMIT       = 400000;
  // settle margin after the last result, before touching config
  localparam int DRAIN_CYCLES      = 40;
  localparam int ITEMS_PER_SETTING = 53;

  localparam logic signed [VAL_W-1:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [VAL_W-1:0] Q_MIN = 32'sh8000_0000;
  localparam logic [COEF_W-1:0] COEF_MAX = 16'h7fff;
  localparam logic [COEF_W-1:0] COEF_MIN = 16'h8000;
  localparam logic [COEF_W-1:0] Q12_ONE  = 16'h1000;
  localparam logic [COEF_W-1:0] Q12_HALF = 16'h0800;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 sample_valid = 1'b0;
  logic                 sample_stall;
  kso_in_t              request_bus  = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  kso_out_t             result_bus;

  logic                 psel    = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite  = 1'b0;
  logic [PADDR_W-1:0]   paddr   = '0;
  logic [PDATA_W-1:0]   pwdata  = '0;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  // model state: coefficient registers and the running estimate
  logic [PDATA_W-1:0]       coef_regs [0:4] = '{default: '0};
  logic signed [VAL_W-1:0]  est_q     [0:1] = '{default: '0};
  kso_out_t                 expected_updates [$];

  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          field_errors   = 0;
  int unsigned cycle_count    = 0;

  always #6 clk = ~clk;

  kalman_state_observer_step dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (request_bus),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result_bus),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // ---------------------------------------------------------------------
  // Model
  // ---------------------------------------------------------------------

  // signed Q4.12 coefficient from its 16-bit slot in a register
  function automatic longint coef_at(input logic [2:0] idx, input int slot);
    logic signed [COEF_W-1:0] c;
    c = coef_regs[idx][slot*COEF_W +: COEF_W];
    return longint'(c);
  endfunction

  // Q20.28 sum -> Q16.16: add half an LSB, floor shift, clamp to 32 bits
  function automatic logic signed [VAL_W-1:0] round_sat(input longint acc);
    longint q;
    q = (acc + (longint'(1) <<< (FRAC_SH - 1))) >>> FRAC_SH;
    if (q > longint'(Q_MAX)) return Q_MAX;
    if (q < longint'(Q_MIN)) return Q_MIN;
    return q[VAL_W-1:0];
  endfunction

  // One observer step: prediction from the old estimate, then the update.
  // Innovation stays exact (33 bits); only yhat and xhat' saturate.
  function automatic kso_out_t predict_update(input kso_in_t req);
    longint   u, x0, x1, inn0, inn1;
    kso_out_t r;
    u  = longint'(req.drive_u);
    x0 = longint'(est_q[0]);
    x1 = longint'(est_q[1]);
    r.pred_angle = round_sat(coef_at(REG_C, 0) * x0 + coef_at(REG_C, 1) * x1
                             + coef_at(REG_D, 0) * u);
    r.pred_rate  = round_sat(coef_at(REG_C, 2) * x0 + coef_at(REG_C, 3) * x1
                             + coef_at(REG_D, 1) * u);
    inn0 = longint'(req.meas_angle) - longint'(r.pred_angle);
    inn1 = longint'(req.meas_rate) - longint'(r.pred_rate);
    r.est_angle = round_sat(coef_at(REG_A, 0) * x0 + coef_at(REG_A, 1) * x1
                            + coef_at(REG_B, 0) * u
                            + coef_at(REG_L, 0) * inn0 + coef_at(REG_L, 1) * inn1);
    r.est_rate  = round_sat(coef_at(REG_A, 2) * x0 + coef_at(REG_A, 3) * x1
                            + coef_at(REG_B, 1) * u
                            + coef_at(REG_L, 2) * inn0 + coef_at(REG_L, 3) * inn1);
    est_q[0] = r.est_angle;
    est_q[1] = r.est_rate;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Monitors and receiver
  // ---------------------------------------------------------------------

  // every accepted request steps the model once
  always @(posedge clk) begin
    if (!rst && sample_valid && !sample_stall)
      expected_updates.insert(expected_updates.size(), predict_update(request_bus));
  end

  task automatic check_field(input string name, input logic [VAL_W-1:0] want,
                             input logic [VAL_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
      field_errors++;
    end
  endtask

  always @(posedge clk) begin : check_results
    kso_out_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_updates.size() == 0) begin
        $error("result with no request outstanding: %h", result_bus);
        field_errors++;
      end else begin
        want = expected_updates.pop_front();
        check_field("est_angle",  want.est_angle,  result_bus.est_angle);
        check_field("est_rate",   want.est_rate,   result_bus.est_rate);
        check_field("pred_angle", want.pred_angle, result_bus.pred_angle);
        check_field("pred_rate",  want.pred_rate,  result_bus.pred_rate);
      end
    end
  end

  // receiver back-pressure, redrawn every cycle
  always @(negedge clk) begin
    result_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // run-away guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Drivers (all called at a falling edge, return at a falling edge)
  // ---------------------------------------------------------------------

  // Random idle cycles first (payload scrambled while valid is low), then
  // hold the request until it is taken. Valid is left high on return so
  // back-to-back requests see no bubble.
  task automatic send_request(input kso_in_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_valid = 1'b0;
      request_bus  = {$urandom, $urandom, $urandom};
      @(negedge clk);
    end
    sample_valid = 1'b1;
    request_bus  = req;
    do @(posedge clk); while (sample_stall);
    @(negedge clk);
  endtask

  task automatic send_fields(input logic signed [VAL_W-1:0] u, ang, rate);
    kso_in_t req;
    req.drive_u    = u;
    req.meas_angle = ang;
    req.meas_rate  = rate;
    send_request(req);
  endtask

  // drop valid, drain every outstanding result, then let the pipe settle
  task automatic wait_idle();
    sample_valid = 1'b0;
    while (expected_updates.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // setup + access; the write lands on the rising edge inside access.
  // Model copy follows the register rules: unmapped slots drop the write,
  // 32-bit registers keep only the low word.
  task automatic apb_write(input logic [2:0] idx, input logic [PDATA_W-1:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 3'b000};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    if (idx <= REG_L) begin
      if (idx == REG_B || idx == REG_D)
        coef_regs[idx] = {32'h0, value[31:0]};
      else
        coef_regs[idx] = value;
    end
  endtask

  task automatic apb_read(input logic [2:0] idx, output logic [PDATA_W-1:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = {idx, 3'b000};
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    value = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  function automatic logic [PDATA_W-1:0] pack4(input logic [COEF_W-1:0] c0, c1, c2, c3);
    return {c3, c2, c1, c0};
  endfunction

  // upper word is junk on purpose: the 32-bit registers must drop it
  function automatic logic [PDATA_W-1:0] pack2(input logic [COEF_W-1:0] c0, c1);
    return {$urandom, c1, c0};
  endfunction

  // full reload of all five registers, with a stray unmapped write now and then
  task automatic load_coefficients(input logic [PDATA_W-1:0] a, b, c, d, l);
    wait_idle();
    apb_write(REG_A, a);
    apb_write(REG_B, b);
    apb_write(REG_C, c);
    apb_write(REG_D, d);
    apb_write(REG_L, l);
    if ($urandom_range(1))
      apb_write(REG_L + 3'($urandom_range(1, 3)), {$urandom, $urandom});
  endtask

  // ---------------------------------------------------------------------
  // Random sources
  // ---------------------------------------------------------------------

  // mostly plant-sized values, some full range, some rails
  function automatic logic signed [VAL_W-1:0] rand_value();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(9))
      0:       return r;
      1:       return r[0] ? Q_MAX : Q_MIN;
      2, 3, 4: return {{6{r[25]}}, r[25:0]};
      default: return {{12{r[19]}}, r[19:0]};
    endcase
  endfunction

  function automatic kso_in_t rand_request();
    kso_in_t req;
    req.drive_u    = rand_value();
    req.meas_angle = rand_value();
    req.meas_rate  = rand_value();
    return req;
  endfunction

  // small signed perturbation, about +-0.016
  function automatic logic [COEF_W-1:0] jitter();
    logic [31:0] r;
    r = $urandom;
    return {{9{r[6]}}, r[6:0]};
  endfunction

  function automatic logic [COEF_W-1:0] rand_coef();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(7))
      0:       return r[15:0];
      1:       return COEF_MAX;
      2:       return COEF_MIN;
      3:       return Q12_ONE;
      default: return {{6{r[9]}}, r[9:0]};
    endcase
  endfunction

  // kind 0: stable angle/rate plant with modest gains
  // kind 1: raw 16-bit coefficients
  // kind 2: mix of rails, unity and small values
  // other:  every coefficient at one rail
  task automatic load_random_setting(input int kind, input bit high_rail);
    logic [COEF_W-1:0] c [0:15];
    case (kind)
      0: begin
        c[0]  = Q12_ONE - 16'($urandom_range(0, 64));
        c[1]  = 16'($urandom_range(32, 400));
        c[2]  = 16'h0000 - 16'($urandom_range(0, 200));
        c[3]  = Q12_ONE - 16'($urandom_range(0, 200));
        c[4]  = jitter();
        c[5]  = 16'($urandom_range(0, 2048));
        c[6]  = Q12_ONE;
        c[7]  = jitter();
        c[8]  = jitter();
        c[9]  = Q12_ONE;
        c[10] = jitter();
        c[11] = jitter();
        c[12] = 16'($urandom_range(512, 3072));
        c[13] = jitter();
        c[14] = jitter();
        c[15] = 16'($urandom_range(512, 3072));
      end
      1: foreach (c[i]) c[i] = 16'($urandom);
      2: foreach (c[i]) c[i] = rand_coef();
      default: foreach (c[i]) c[i] = high_rail ? COEF_MAX : COEF_MIN;
    endcase
    load_coefficients(pack4(c[0], c[1], c[2], c[3]), pack2(c[4], c[5]),
                      pack4(c[6], c[7], c[8], c[9]), pack2(c[10], c[11]),
                      pack4(c[12], c[13], c[14], c[15]));
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // all coefficients reset to zero, so every output must be zero
  task automatic test_reset_state();
    repeat (3) send_request(rand_request());
  endtask

  // write/read back every register; unmapped writes must not disturb them
  task automatic test_register_access();
    logic [PDATA_W-1:0] got;
    wait_idle();
    for (int i = REG_A; i <= REG_L; i++)
      apb_write(3'(i), {$urandom, $urandom});
    for (int i = REG_L + 1; i < 8; i++)
      apb_write(3'(i), {$urandom, $urandom});
    for (int i = REG_A; i <= REG_L; i++) begin
      apb_read(3'(i), got);
      if (got !== coef_regs[i]) begin
        $error("register %0d readback: expected %h, got %h", i, coef_regs[i], got);
        field_errors++;
      end
    end
  endtask

  // Rails on every field, under a unity plant and under all-max / all-min
  // coefficients. Covers saturated prediction, a full 33-bit innovation
  // (estimate at one rail, measurement at the other) and estimate clamping.
  task automatic test_directed_extremes();
    load_coefficients(pack4(Q12_ONE, '0, '0, Q12_ONE), pack2(Q12_ONE, Q12_HALF),
                      pack4(Q12_ONE, '0, '0, Q12_ONE), pack2('0, '0),
                      pack4(Q12_HALF, '0, '0, Q12_HALF));
    send_fields('0, '0, '0);
    send_fields(Q_MAX, Q_MAX, Q_MAX);
    send_fields(Q_MAX, Q_MAX, Q_MAX);
    send_fields(Q_MIN, Q_MIN, Q_MIN);
    send_fields(Q_MIN, Q_MAX, Q_MIN);
    send_fields(Q_MAX, Q_MIN, Q_MAX);
    send_fields(32'sd1, -32'sd1, 32'sd1);
    send_fields(-32'sd1, 32'sd1, -32'sd1);
    for (int rail = 0; rail < 2; rail++) begin
      load_random_setting(3, rail[0]);
      send_fields(Q_MAX, Q_MAX, Q_MAX);
      send_fields(Q_MIN, Q_MIN, Q_MIN);
      send_fields(Q_MAX, Q_MIN, Q_MAX);
      send_fields('0, '0, '0);
      send_fields(Q_MIN, Q_MAX, Q_MIN);
      send_fields(32'sd1, -32'sd1, -32'sd1);
    end
  endtask

  // four back-pressure phases, each run over all four setting kinds
  task automatic test_random_traffic();
    int idle_by_phase  [0:3] = '{0, 84, 0, 23};
    int stall_by_phase [0:3] = '{0, 0, 84, 23};
    for (int p = 0; p < 4; p++) begin
      for (int k = 0; k < 4; k++) begin
        load_random_setting(k, p[0]);
        send_idle_pct  = idle_by_phase[p];
        recv_stall_pct = stall_by_phase[p];
        repeat (ITEMS_PER_SETTING) send_request(rand_request());
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_state();
    test_register_access();
    test_directed_extremes();
    test_random_traffic();

    wait_idle();
    if (field_errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
